[hw/rtl/lzwp_pkg.sv]
// Shared types, constants and helpers for the pruning LZW encoder.
// No dependencies; the other files that use it refer to this package by scoped names.
package lzwp_pkg;

  localparam int DICT_DEPTH = 4096;
  localparam int ROOT_COUNT = 256;
  localparam int CODE_W     = 12;
  localparam int CNT_W      = 13;
  localparam int ADDR_W     = 12;
  localparam int PADDR_W    = 3;

  localparam logic [CNT_W-1:0] EMPTY_CODE = 13'h1FFF;
  localparam logic [CNT_W-1:0] ROOTS      = 13'd256;
  localparam logic [3:0]       WIDTH_MIN  = 4'd9;
  localparam logic [3:0]       WIDTH_MAX  = 4'd12;
  localparam logic [3:0]       MAX_BITS_RST = 4'd12;

  // register index taken from paddr[2]
  localparam logic REG_MAX_BITS = 1'b0;
  localparam logic REG_PRUNE    = 1'b1;

  typedef struct packed {
    logic       action;
    logic [7:0] data_byte;
  } in_t;

  typedef struct packed {
    logic [11:0] code;
    logic [3:0]  code_width;
    logic        final_code;
  } out_t;

  typedef struct packed {
    logic [CODE_W-1:0] prefix;
    logic [7:0]        byte_val;
  } entry_t;

  typedef struct packed {
    logic              used;
    logic [CODE_W-1:0] new_code;
  } prune_t;

  typedef struct packed {
    logic [3:0] max_bits;
    logic       prune_en;
  } cfg_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_START,
    S_SCAN,
    S_MISS,
    S_CLR,
    S_MARK,
    S_CRD,
    S_CCHK,
    S_CWR,
    S_POST
  } state_t;

  function automatic logic [3:0] eff_bits(input logic [3:0] b);
    logic [3:0] r;
    r = b;
    if (b < WIDTH_MIN) r = WIDTH_MIN;
    if (b > WIDTH_MAX) r = WIDTH_MAX;
    return r;
  endfunction

  function automatic logic [CNT_W-1:0] capacity(input logic [3:0] b);
    return CNT_W'(1) << eff_bits(b);
  endfunction

endpackage

[hw/rtl/lzwp_ram.sv]
// Generic single-write, single-read synchronous RAM with a registered read.
// Depends on nothing.
module lzwp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[hw/rtl/lzwp_cfg.sv]
// APB-style register file: max_bits and prune_enable.
// Depends on lzwp_pkg.
module lzwp_cfg (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [lzwp_pkg::PADDR_W-1:0] paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready,
  output lzwp_pkg::cfg_t              cfg
);

  lzwp_pkg::cfg_t cfg_r, cfg_nxt;

  assign pready = 1'b1;
  assign cfg    = cfg_r;

  always_comb begin
    cfg_nxt = cfg_r;
    if (psel && penable && pwrite) begin
      unique case (paddr[2])
        lzwp_pkg::REG_MAX_BITS: cfg_nxt.max_bits = pwdata[3:0];
        lzwp_pkg::REG_PRUNE:    cfg_nxt.prune_en = pwdata[0];
        default:                cfg_nxt = cfg_r;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      lzwp_pkg::REG_MAX_BITS: prdata = {28'd0, cfg_r.max_bits};
      lzwp_pkg::REG_PRUNE:    prdata = {31'd0, cfg_r.prune_en};
      default:                prdata = 32'd0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.max_bits <= lzwp_pkg::MAX_BITS_RST;
      cfg_r.prune_en <= 1'b0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule

[hw/rtl/lzw_encoder_pruning_unit.sv]
// Top level of the pruning LZW encoder: control sequencer, dictionary and
// prune memories. Depends on lzwp_pkg, lzwp_ram and lzwp_cfg.
//
//   channel   direction  handshake            word
//   in_       input      in_valid / in_stall   in_t  {action, data_byte}
//   out_      output     out_valid / out_stall out_t {code, code_width, final_code}
//   cfg (APB) input      psel/penable/pready   max_bits, prune_enable
//
// A byte whose match is empty, or an end of stream, is handled in S_START. Otherwise
// the dictionary RAM is walked one entry a cycle from code 256 up to the fill
// count; a miss then emits the match in S_MISS.
// A prune runs clear and mark sweeps over the non-root entries, then takes each
// one through S_CRD, S_CCHK and, if kept, S_CWR; S_POST adds the missed pair.
// Reset is synchronous; roots are implied. A miss, or a flush of an open match,
// holds while the output register is stalled; the input is taken only while idle.
module lzw_encoder_pruning_unit (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  lzwp_pkg::in_t                in_data,
  output logic                         out_valid,
  input  logic                         out_stall,
  output lzwp_pkg::out_t               out_data,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [lzwp_pkg::PADDR_W-1:0] paddr,
  input  logic [31:0]                  pwdata,
  output logic [31:0]                  prdata,
  output logic                         pready
);

  localparam int CW = lzwp_pkg::CNT_W;
  localparam int AW = lzwp_pkg::ADDR_W;

  lzwp_pkg::cfg_t   cfg;
  lzwp_pkg::state_t state_r, state_nxt;

  logic          act_r, act_nxt;
  logic [7:0]    byte_r, byte_nxt;
  logic [CW-1:0] match_r, match_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic [3:0]    width_r, width_nxt;
  logic [CW-1:0] i_r, i_nxt;
  logic [CW-1:0] k_r, k_nxt;
  logic [CW-1:0] n_r, n_nxt;
  logic [AW-1:0] p_r, p_nxt;
  logic [7:0]    b_r, b_nxt;
  logic          out_valid_r, out_valid_nxt;
  lzwp_pkg::out_t out_r, out_nxt;

  // dictionary RAM: non-root entries, word = {prefix, byte}
  logic              e_we;
  logic [AW-1:0]     e_waddr, e_raddr;
  lzwp_pkg::entry_t  e_wdata, e_rdata;

  // prune RAM: per entry {used as prefix, new code}
  logic              q_we;
  logic [AW-1:0]     q_waddr, q_raddr;
  lzwp_pkg::prune_t  q_wdata, q_rdata;

  logic          out_free;
  logic [CW-1:0] cap;
  logic [3:0]    eff;
  logic [CW-1:0] i_inc;
  logic [CW-1:0] cnt_inc;
  logic [CW-1:0] rd_prefix;
  logic [AW-1:0] remapped;

  lzwp_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  lzwp_ram #(
    .WIDTH ($bits(lzwp_pkg::entry_t)),
    .DEPTH (lzwp_pkg::DICT_DEPTH)
  ) u_dict (
    .clk   (clk),
    .we    (e_we),
    .waddr (e_waddr),
    .wdata (e_wdata),
    .raddr (e_raddr),
    .rdata (e_rdata)
  );

  lzwp_ram #(
    .WIDTH ($bits(lzwp_pkg::prune_t)),
    .DEPTH (lzwp_pkg::DICT_DEPTH)
  ) u_prune (
    .clk   (clk),
    .we    (q_we),
    .waddr (q_waddr),
    .wdata (q_wdata),
    .raddr (q_raddr),
    .rdata (q_rdata)
  );

  assign in_stall  = (state_r != lzwp_pkg::S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_r;
  assign out_free  = !out_valid_r || !out_stall;
  assign eff       = lzwp_pkg::eff_bits(cfg.max_bits);
  assign cap       = lzwp_pkg::capacity(cfg.max_bits);
  assign i_inc     = i_r + CW'(1);
  assign cnt_inc   = count_r + CW'(1);
  assign rd_prefix = {1'b0, e_rdata.prefix};

  // Remap a kept entry's prefix: only codes already renumbered in this pass
  // move; a self-reference takes the code being assigned now.
  always_comb begin
    remapped = p_r;
    if ({1'b0, p_r} >= lzwp_pkg::ROOTS) begin
      if ({1'b0, p_r} == i_r) begin
        remapped = k_r[AW-1:0];
      end else if (({1'b0, p_r} < i_r) && q_rdata.used) begin
        remapped = q_rdata.new_code;
      end
    end
  end

  always_comb begin
    state_nxt     = state_r;
    act_nxt       = act_r;
    byte_nxt      = byte_r;
    match_nxt     = match_r;
    count_nxt     = count_r;
    width_nxt     = width_r;
    i_nxt         = i_r;
    k_nxt         = k_r;
    n_nxt         = n_r;
    p_nxt         = p_r;
    b_nxt         = b_r;
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r && out_stall;
    e_we          = 1'b0;
    e_waddr       = count_r[AW-1:0];
    e_wdata       = '{prefix: match_r[AW-1:0], byte_val: byte_r};
    e_raddr       = i_r[AW-1:0];
    q_we          = 1'b0;
    q_waddr       = i_r[AW-1:0];
    q_wdata       = '0;
    q_raddr       = i_r[AW-1:0];

    unique case (state_r)
      lzwp_pkg::S_IDLE: begin
        if (in_valid) begin
          act_nxt   = in_data.action;
          byte_nxt  = in_data.data_byte;
          state_nxt = lzwp_pkg::S_START;
        end
      end

      lzwp_pkg::S_START: begin
        if (act_r) begin
          // end of stream: flush the match, then reinitialise
          if (match_r == lzwp_pkg::EMPTY_CODE || out_free) begin
            if (match_r != lzwp_pkg::EMPTY_CODE) begin
              out_valid_nxt = 1'b1;
              out_nxt = '{code: match_r[11:0], code_width: width_r, final_code: 1'b1};
            end
            count_nxt = lzwp_pkg::ROOTS;
            match_nxt = lzwp_pkg::EMPTY_CODE;
            width_nxt = lzwp_pkg::WIDTH_MIN;
            state_nxt = lzwp_pkg::S_IDLE;
          end
        end else if (match_r == lzwp_pkg::EMPTY_CODE) begin
          // empty match always hits its root
          match_nxt = {5'd0, byte_r};
          state_nxt = lzwp_pkg::S_IDLE;
        end else if (count_r == lzwp_pkg::ROOTS) begin
          state_nxt = lzwp_pkg::S_MISS;
        end else begin
          e_raddr   = lzwp_pkg::ROOTS[AW-1:0];
          i_nxt     = lzwp_pkg::ROOTS;
          state_nxt = lzwp_pkg::S_SCAN;
        end
      end

      lzwp_pkg::S_SCAN: begin
        if (e_rdata.prefix == match_r[AW-1:0] && e_rdata.byte_val == byte_r) begin
          match_nxt = i_r;
          state_nxt = lzwp_pkg::S_IDLE;
        end else if (i_inc == count_r) begin
          state_nxt = lzwp_pkg::S_MISS;
        end else begin
          e_raddr = i_inc[AW-1:0];
          i_nxt   = i_inc;
        end
      end

      lzwp_pkg::S_MISS: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_nxt = '{code: match_r[11:0], code_width: width_r, final_code: 1'b0};
          if (count_r < cap) begin
            e_we      = 1'b1;
            count_nxt = cnt_inc;
            if (cnt_inc >= (CW'(1) << width_r) && width_r < eff) begin
              width_nxt = width_r + 4'd1;
            end
            match_nxt = {5'd0, byte_r};
            state_nxt = lzwp_pkg::S_IDLE;
          end else if (cfg.prune_en) begin
            n_nxt     = count_r;
            i_nxt     = lzwp_pkg::ROOTS;
            state_nxt = lzwp_pkg::S_CLR;
          end else begin
            match_nxt = {5'd0, byte_r};
            state_nxt = lzwp_pkg::S_IDLE;
          end
        end
      end

      lzwp_pkg::S_CLR: begin
        // drop all used marks of the non-root entries
        q_we = 1'b1;
        if (i_inc == n_r) begin
          i_nxt     = lzwp_pkg::ROOTS;
          e_raddr   = lzwp_pkg::ROOTS[AW-1:0];
          state_nxt = lzwp_pkg::S_MARK;
        end else begin
          i_nxt = i_inc;
        end
      end

      lzwp_pkg::S_MARK: begin
        // flag every non-root code that some entry uses as its prefix
        if (rd_prefix >= lzwp_pkg::ROOTS && rd_prefix < n_r) begin
          q_we    = 1'b1;
          q_waddr = e_rdata.prefix;
          q_wdata = '{used: 1'b1, new_code: '0};
        end
        if (i_inc == n_r) begin
          i_nxt     = lzwp_pkg::ROOTS;
          k_nxt     = lzwp_pkg::ROOTS;
          state_nxt = lzwp_pkg::S_CRD;
        end else begin
          i_nxt   = i_inc;
          e_raddr = i_inc[AW-1:0];
        end
      end

      lzwp_pkg::S_CRD: begin
        state_nxt = lzwp_pkg::S_CCHK;
      end

      lzwp_pkg::S_CCHK: begin
        if (q_rdata.used) begin
          p_nxt     = e_rdata.prefix;
          b_nxt     = e_rdata.byte_val;
          q_raddr   = e_rdata.prefix;
          state_nxt = lzwp_pkg::S_CWR;
        end else if (i_inc == n_r) begin
          count_nxt = k_r;
          state_nxt = lzwp_pkg::S_POST;
        end else begin
          i_nxt     = i_inc;
          state_nxt = lzwp_pkg::S_CRD;
        end
      end

      lzwp_pkg::S_CWR: begin
        e_we    = 1'b1;
        e_waddr = k_r[AW-1:0];
        e_wdata = '{prefix: remapped, byte_val: b_r};
        q_we    = 1'b1;
        q_wdata = '{used: 1'b1, new_code: k_r[AW-1:0]};
        k_nxt   = k_r + CW'(1);
        if (i_inc == n_r) begin
          count_nxt = k_r + CW'(1);
          state_nxt = lzwp_pkg::S_POST;
        end else begin
          i_nxt     = i_inc;
          state_nxt = lzwp_pkg::S_CRD;
        end
      end

      lzwp_pkg::S_POST: begin
        // add the missed pair with its pre-prune prefix if room was made
        if (count_r < cap) begin
          e_we      = 1'b1;
          count_nxt = cnt_inc;
          if (cnt_inc >= (CW'(1) << width_r) && width_r < eff) begin
            width_nxt = width_r + 4'd1;
          end
        end
        match_nxt = {5'd0, byte_r};
        state_nxt = lzwp_pkg::S_IDLE;
      end

      default: state_nxt = lzwp_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= lzwp_pkg::S_IDLE;
      match_r     <= lzwp_pkg::EMPTY_CODE;
      count_r     <= lzwp_pkg::ROOTS;
      width_r     <= lzwp_pkg::WIDTH_MIN;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      match_r     <= match_nxt;
      count_r     <= count_nxt;
      width_r     <= width_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    act_r  <= act_nxt;
    byte_r <= byte_nxt;
    i_r    <= i_nxt;
    k_r    <= k_nxt;
    n_r    <= n_nxt;
    p_r    <= p_nxt;
    b_r    <= b_nxt;
    out_r  <= out_nxt;
  end

`ifndef SYNTH
  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    (count_r >= lzwp_pkg::ROOTS) && (count_r <= CW'(lzwp_pkg::DICT_DEPTH)))
    else $error("fill count out of range");

  a_width_grows: assert property (@(posedge clk) disable iff (!rst_n)
    !(state_r == lzwp_pkg::S_START && act_r) |=> width_r >= $past(width_r))
    else $error("code width shrank outside a flush");

  a_compact_order: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == lzwp_pkg::S_CWR) |-> (k_r <= i_r))
    else $error("compaction write overtook its read");

  a_miss_emits: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == lzwp_pkg::S_MISS && out_free) |=> out_valid_r)
    else $error("miss left no word in the output register");
`endif

endmodule

[bench/lzw_encoder_pruning_unit_tb.sv]
// Self-checking testbench for the pruning LZW encoder top level.
// Depends on lzwp_pkg (word types, dictionary constants) and the RTL below it.
module lzw_encoder_pruning_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic       ACT_DATA      = 1'b0;
  localparam logic       ACT_FLUSH     = 1'b1;
  localparam logic [2:0] ADDR_MAX_BITS = 3'd0;
  localparam logic [2:0] ADDR_PRUNE    = 3'd4;
  // Longest quiet stretch of a correct run: a prune over a full 4096 entry
  // dictionary plus a full scan, with generous margin.
  localparam int SETTLE_CYCLES = 6 * lzwp_pkg::DICT_DEPTH;
  localparam int HANG_LIMIT    = 200000;

  logic           clk = 1'b0;
  logic           rst_n;
  logic           in_valid;
  logic           in_stall;
  lzwp_pkg::in_t  in_data;
  logic           out_valid;
  logic           out_stall;
  lzwp_pkg::out_t out_data;
  logic           psel, penable, pwrite;
  logic [2:0]     paddr;
  logic [31:0]    pwdata, prdata;
  logic           pready;

  always #5 clk = ~clk;

  lzw_encoder_pruning_unit dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  // ---------------------------------------------------------------------
  // Encoder shadow: dictionary, match and width tracked in step with the
  // block, plus its copy of the two registers.
  // ---------------------------------------------------------------------
  logic [12:0] dict_prefix [lzwp_pkg::DICT_DEPTH];
  logic [7:0]  dict_byte   [lzwp_pkg::DICT_DEPTH];
  int unsigned dict_fill;
  logic [12:0] match_code;
  int unsigned code_width_now;
  logic [3:0]  shadow_max_bits;
  logic        shadow_prune;

  lzwp_pkg::out_t code_queue[$];   // words still owed by the block
  int          mismatches;
  int          words_sent, codes_seen, flush_codes, prune_passes;
  bit          calm;            // no idling on either side
  int          quiet_cycles = 0;

  function automatic int unsigned width_limit();
    if (shadow_max_bits < 4'd9) return 9;
    if (shadow_max_bits > 4'd12) return 12;
    return 32'(shadow_max_bits);
  endfunction

  function automatic void dict_restart();
    for (int i = 0; i < lzwp_pkg::ROOT_COUNT; i++) begin
      dict_prefix[i] = lzwp_pkg::EMPTY_CODE;
      dict_byte[i]   = 8'(i);
    end
    dict_fill      = lzwp_pkg::ROOT_COUNT;
    match_code     = lzwp_pkg::EMPTY_CODE;
    code_width_now = 9;
  endfunction

  function automatic void dict_append(logic [12:0] pre, logic [7:0] b);
    if (dict_fill >= lzwp_pkg::DICT_DEPTH) return;
    dict_prefix[dict_fill] = pre;
    dict_byte[dict_fill]   = b;
    dict_fill++;
    if (dict_fill > (1 << code_width_now) - 1 && code_width_now < width_limit())
      code_width_now++;
  endfunction

  // Keep roots and entries that are prefixes, compact them in order and
  // remap prefixes through the new numbering.
  function automatic void dict_prune();
    bit          has_child [lzwp_pkg::DICT_DEPTH];
    int unsigned remap [lzwp_pkg::DICT_DEPTH];
    int unsigned n, k;
    logic [12:0] p;
    n = (dict_fill > lzwp_pkg::DICT_DEPTH) ? lzwp_pkg::DICT_DEPTH : dict_fill;
    k = 0;
    for (int i = 0; i < lzwp_pkg::DICT_DEPTH; i++) begin
      has_child[i] = 1'b0;
      remap[i]     = i;
    end
    for (int i = 0; i < n; i++) begin
      p = dict_prefix[i];
      if (p != lzwp_pkg::EMPTY_CODE && p < n) has_child[p] = 1'b1;
    end
    for (int i = 0; i < n; i++) begin
      p = dict_prefix[i];
      if (p != lzwp_pkg::EMPTY_CODE && !has_child[i]) continue;
      if (i >= lzwp_pkg::ROOT_COUNT) remap[i] = k;
      if (p != lzwp_pkg::EMPTY_CODE && p >= lzwp_pkg::ROOT_COUNT &&
          p < lzwp_pkg::DICT_DEPTH)
        p = 13'(remap[p]);
      dict_prefix[k] = p;
      dict_byte[k]   = dict_byte[i];
      k++;
    end
    dict_fill = k;
    prune_passes++;
  endfunction

  function automatic void lzw_predict(lzwp_pkg::in_t w);
    lzwp_pkg::out_t owed;
    int unsigned    hit;
    if (w.action == ACT_FLUSH) begin
      if (match_code != lzwp_pkg::EMPTY_CODE) begin
        owed.code       = match_code[11:0];
        owed.code_width = 4'(code_width_now);
        owed.final_code = 1'b1;
        code_queue.push_back(owed);
      end
      dict_restart();
      return;
    end
    hit = lzwp_pkg::DICT_DEPTH;
    for (int i = 0; i < dict_fill && i < lzwp_pkg::DICT_DEPTH; i++)
      if (dict_prefix[i] == match_code && dict_byte[i] == w.data_byte) begin
        hit = i;
        break;
      end
    if (hit != lzwp_pkg::DICT_DEPTH) begin
      match_code = 13'(hit);
      return;
    end
    owed.code       = match_code[11:0];
    owed.code_width = 4'(code_width_now);
    owed.final_code = 1'b0;
    code_queue.push_back(owed);
    if (dict_fill < (1 << width_limit())) dict_append(match_code, w.data_byte);
    else if (shadow_prune) begin
      dict_prune();
      // new entry keeps the prefix number from before the prune
      if (match_code != lzwp_pkg::EMPTY_CODE && dict_fill < (1 << width_limit()))
        dict_append(match_code, w.data_byte);
    end
    match_code = {5'd0, w.data_byte};
  endfunction

  // ---------------------------------------------------------------------
  // Result side: random stall bursts, and a checker on every accepted word.
  // ---------------------------------------------------------------------
  int stall_left;
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall  <= 1'b0;
      stall_left <= 0;
    end else if (stall_left != 0) begin
      stall_left <= stall_left - 1;
      out_stall  <= 1'b1;
    end else if (!calm && $urandom_range(0, 19) == 0) begin
      stall_left <= $urandom_range(0, 11);
      out_stall  <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  always @(posedge clk) begin
    lzwp_pkg::out_t owed;
    if (rst_n && out_valid && !out_stall) begin
      codes_seen++;
      if (code_queue.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("[%0t] unexpected code word %h (code %0d width %0d final %0b)",
                   $realtime, out_data, out_data.code, out_data.code_width,
                   out_data.final_code);
      end else begin
        owed = code_queue.pop_front();
        if (owed.final_code) flush_codes++;
        if (out_data.code !== owed.code || out_data.code_width !== owed.code_width ||
            out_data.final_code !== owed.final_code) begin
          mismatches++;
          if (mismatches <= 10)
            $display({"[%0t] code word mismatch: expected code %0d width %0d ",
                      "final %0b, got code %0d width %0d final %0b"},
                     $realtime, owed.code, owed.code_width, owed.final_code,
                     out_data.code, out_data.code_width, out_data.final_code);
        end
      end
    end
  end

  // Watchdog: count cycles in which neither channel moves a word.
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= HANG_LIMIT) begin
      $display("watchdog: no word moved for %0d cycles, %0d codes owed",
               HANG_LIMIT, code_queue.size());
      $display("FAILURE");
      $finish;
    end
  end

  // ---------------------------------------------------------------------
  // Drivers
  // ---------------------------------------------------------------------
  task automatic cfg_write(logic [2:0] addr, logic [31:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (addr == ADDR_MAX_BITS) shadow_max_bits = value[3:0];
    else if (addr == ADDR_PRUNE) shadow_prune = value[0];
  endtask

  // Offer one word and hold it until taken. Valid is left high; callers
  // drop it with input_release before waiting on anything else.
  task automatic send_word(logic act, logic [7:0] b);
    lzwp_pkg::in_t w;
    w.action    = act;
    w.data_byte = b;
    if (!calm && $urandom_range(0, 9) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= w;
    do @(posedge clk); while (in_stall);
    lzw_predict(w);
    words_sent++;
  endtask

  task automatic input_release();
    in_valid <= 1'b0;
    @(posedge clk);
  endtask

  // Wait until every owed code has arrived (sender paused).
  task automatic await_codes();
    input_release();
    while (code_queue.size() != 0) @(posedge clk);
  endtask

  // Fully idle: owed codes in, then let any hit scan or prune finish.
  task automatic settle();
    await_codes();
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Random stream: mostly bytes from a small alphabet so strings repeat and
  // the dictionary fills; now and then a full-range byte or a stray flush.
  task automatic send_stream(int count, int alphabet, int flush_per_mille);
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(0, 999) < flush_per_mille) send_word(ACT_FLUSH, 8'($urandom));
      else if ($urandom_range(0, 9) == 0) send_word(ACT_DATA, 8'($urandom));
      else send_word(ACT_DATA, 8'($urandom_range(0, alphabet - 1)));
    end
  endtask

  // ---------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------
  // Defaults after reset: empty flush, field extremes, hits, misses, flush.
  task automatic test_directed();
    logic [7:0] seq [12] = '{8'h00, 8'hFF, 8'h00, 8'hFF, 8'h00, 8'hFF,
                             8'h00, 8'hFF, 8'hA5, 8'h5A, 8'hA5, 8'h5A};
    send_word(ACT_FLUSH, 8'hFF);            // nothing matched yet
    foreach (seq[i]) send_word(ACT_DATA, seq[i]);
    send_word(ACT_FLUSH, 8'h00);            // flushes the open match
    send_word(ACT_FLUSH, 8'h00);            // empty again
    settle();
  endtask

  // Width above range clamps to 12; no pruning, wide random bytes.
  task automatic test_wide_frozen();
    cfg_write(ADDR_MAX_BITS, ($urandom() & 32'hFFFF_FFF0) | 32'hF);
    cfg_write(ADDR_PRUNE, 32'h0);
    send_stream(60, 256, 10);
    send_word(ACT_FLUSH, 8'h00);
    settle();
  endtask

  // Width 10 with pruning: fill past 511 entries so the code width grows.
  task automatic test_growth();
    cfg_write(ADDR_MAX_BITS, 32'd10);
    cfg_write(ADDR_PRUNE, $urandom() | 32'h1);
    send_stream(420, 32, 0);
    settle();
  endtask

  // Lower the width mid-stream: dictionary counts as full, prunes follow,
  // and the code width must not shrink.
  task automatic test_lowered_width();
    cfg_write(ADDR_MAX_BITS, 32'd9);
    send_stream(150, 16, 0);
    send_word(ACT_FLUSH, 8'h00);
    settle();
  endtask

  // Width below range clamps to 9; no pruning, so the dictionary freezes.
  task automatic test_clamp_freeze();
    cfg_write(ADDR_MAX_BITS, 32'hFFFF_FFF0);
    cfg_write(ADDR_PRUNE, 32'hFFFF_FFFE);
    send_stream(120, 8, 0);
    send_stream(30, 256, 60);
    settle();
  endtask

  // Pruning again with broken streams; pause the sender once until all
  // codes are in, then finish without idling on either side.
  task automatic test_pressure_tail();
    cfg_write(ADDR_PRUNE, 32'h1);
    send_stream(90, 16, 20);
    await_codes();
    calm = 1'b1;
    send_stream(60, 16, 20);
    send_word(ACT_FLUSH, 8'h00);
    settle();
  endtask

  initial begin
    rst_n    <= 1'b0;
    in_valid <= 1'b0;
    in_data  <= '0;
    psel     <= 1'b0;
    penable  <= 1'b0;
    pwrite   <= 1'b0;
    paddr    <= '0;
    pwdata   <= '0;
    mismatches = 0; words_sent = 0; codes_seen = 0; flush_codes = 0;
    prune_passes = 0; calm = 1'b0;
    shadow_max_bits = lzwp_pkg::MAX_BITS_RST;
    shadow_prune    = 1'b0;
    dict_restart();
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed();
    test_wide_frozen();
    test_growth();
    test_lowered_width();
    test_clamp_freeze();
    test_pressure_tail();

    $display("Sent %0d words, checked %0d codes (%0d end-of-stream), %0d prune passes.",
             words_sent, codes_seen, flush_codes, prune_passes);
    $display("Widths 9..12 with clamping, pruning on and off, lowered width mid-stream.");
    if (mismatches == 0 && code_queue.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("%0d mismatches, %0d codes never arrived", mismatches, code_queue.size());
      $display("FAILURE");
    end
    $finish;
  end

endmodule
